// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tile planner RTL.
// No dependencies; included inside module bodies that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/otp_pkg.sv =====
// Shared types and constants of the overlapped tile planner.
// No dependencies; imported by every module of the block.
package otp_pkg;

  localparam int COORD_WIDTH = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELDS  = 8;
  localparam int OUT_TDATA_W = ((OUT_FIELDS * COORD_WIDTH + 7) / 8) * 8;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_SIZE    = 2'd2,
    REG_OVERLAP_REQ  = 2'd3
  } cfg_reg_t;

  // Next start along one axis and whether the axis wrapped.
  typedef struct packed {
    coord_t start;
    logic   wrap;
  } axis_step_t;

  // Coordinate fields of one result item, tile_x in the lowest bits.
  typedef struct packed {
    coord_t feather_bottom;
    coord_t feather_right;
    coord_t feather_top;
    coord_t feather_left;
    coord_t tile_h;
    coord_t tile_w;
    coord_t tile_y;
    coord_t tile_x;
  } tile_fields_t;

  typedef struct packed {
    logic         last_tile;
    logic         no_tiles;
    tile_fields_t fields;
  } tile_result_t;

endpackage

// ===== rtl/core/otp_axis_next.sv =====
// Next tile start along one axis of the plan.
// Depends on otp_pkg.
module otp_axis_next (
  input  otp_pkg::coord_t     cur,
  input  otp_pkg::coord_t     extent,
  input  otp_pkg::coord_t     tile,
  input  otp_pkg::coord_t     step,
  output otp_pkg::axis_step_t nxt
);
  import otp_pkg::*;

  coord_t               limit;
  logic                 fits;
  logic [COORD_WIDTH:0] sum;

  // The last start on the axis is extent - tile; an axis no longer than
  // the tile has the single start zero and always wraps.
  always_comb begin
    limit     = extent - tile;
    fits      = (extent <= tile);
    sum       = {1'b0, cur} + {1'b0, step};
    nxt.wrap  = fits || (cur >= limit);
    if (nxt.wrap) begin
      nxt.start = '0;
    end else if (sum >= {1'b0, limit}) begin
      nxt.start = limit;
    end else begin
      nxt.start = sum[COORD_WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/core/otp_tile_calc.sv =====
// Size, feather overlaps and last flag of the tile at a given start.
// Depends on otp_pkg.
module otp_tile_calc (
  input  otp_pkg::coord_t      x,
  input  otp_pkg::coord_t      y,
  input  otp_pkg::coord_t      image_width,
  input  otp_pkg::coord_t      image_height,
  input  otp_pkg::coord_t      tile,
  input  otp_pkg::coord_t      overlap,
  output otp_pkg::tile_result_t res
);
  import otp_pkg::*;

  coord_t dx;
  coord_t dy;
  logic   has_right;
  logic   has_below;

  // Starts never pass the extent, so x + w < width reduces to tile < width - x.
  always_comb begin
    dx        = image_width - x;
    dy        = image_height - y;
    has_right = (tile < dx);
    has_below = (tile < dy);

    res.fields.tile_x         = x;
    res.fields.tile_y         = y;
    res.fields.tile_w         = (dx < tile) ? dx : tile;
    res.fields.tile_h         = (dy < tile) ? dy : tile;
    res.fields.feather_left   = (x != '0) ? overlap : '0;
    res.fields.feather_top    = (y != '0) ? overlap : '0;
    res.fields.feather_right  = has_right ? overlap : '0;
    res.fields.feather_bottom = has_below ? overlap : '0;
    res.no_tiles              = 1'b0;
    res.last_tile             = !has_right && !has_below;
  end

endmodule

// ===== rtl/core/overlapped_tile_planner.sv =====
// Overlapped tile planner: one tile of a row-major overlapping grid per item.
// Results go to the output register, or to the skid entry while it stalls.
// One item per cycle while s_axis_tready is high; the cursor update is an add
// and compares per axis; a two-entry output stage keeps input and output apart.
// Reset (rst, synchronous, active high) zeroes config and cursor, empties the
// output stage and rewinds the plan so the next item gives the first tile.
module overlapped_tile_planner (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [otp_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [otp_pkg::COORD_WIDTH-1:0]        cfg_data,
  // Request stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [otp_pkg::IN_TDATA_W-1:0]         s_axis_tdata,   // restart
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tile_x, tile_y, tile_w, tile_h, feather_left, feather_top,
  // feather_right, feather_bottom
  output logic [otp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tuser,   // no_tiles
  output logic                                   m_axis_tlast    // last_tile
);
  import otp_pkg::*;

  coord_t       image_width;
  coord_t       image_height;
  coord_t       tile_size;
  coord_t       overlap_req;
  coord_t       cursor_x;
  coord_t       cursor_y;
  logic         at_start;

  coord_t       tile_m1;
  coord_t       overlap;
  coord_t       step;
  logic         empty_plan;
  logic         first;
  logic         accept;
  coord_t       x_sel;
  coord_t       y_sel;
  axis_step_t   ax;
  axis_step_t   ay;
  tile_result_t calc;
  tile_result_t result;

  tile_result_t out_data;
  logic         out_valid;
  tile_result_t skid_data;
  logic         skid_valid;

  // Configuration registers; any write rewinds the plan.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= '0;
      image_height <= '0;
      tile_size    <= '0;
      overlap_req  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_TILE_SIZE:    tile_size    <= cfg_data;
        REG_OVERLAP_REQ:  overlap_req  <= cfg_data;
      endcase
    end
  end

  // Clamped overlap, step and the empty-plan test.
  always_comb begin
    tile_m1    = tile_size - coord_t'(1);
    overlap    = (overlap_req > tile_m1) ? tile_m1 : overlap_req;
    step       = tile_size - overlap;
    empty_plan = (tile_size == '0) || (image_width == '0) || (image_height == '0) ||
                 ((image_width <= tile_size) && (image_height <= tile_size));
  end

  otp_axis_next u_axis_x (
    .cur    (cursor_x),
    .extent (image_width),
    .tile   (tile_size),
    .step   (step),
    .nxt    (ax)
  );

  otp_axis_next u_axis_y (
    .cur    (cursor_y),
    .extent (image_height),
    .tile   (tile_size),
    .step   (step),
    .nxt    (ay)
  );

  // Pick the start of the tile for this item: first tile or next in row order.
  always_comb begin
    accept = s_axis_tvalid && s_axis_tready;
    first  = s_axis_tdata[0] || at_start;
    x_sel  = first ? '0 : ax.start;
    if (first) begin
      y_sel = '0;
    end else if (ax.wrap) begin
      y_sel = ay.start;
    end else begin
      y_sel = cursor_y;
    end
  end

  otp_tile_calc u_tile_calc (
    .x            (x_sel),
    .y            (y_sel),
    .image_width  (image_width),
    .image_height (image_height),
    .tile         (tile_size),
    .overlap      (overlap),
    .res          (calc)
  );

  // An empty plan reports only the no_tiles flag.
  always_comb begin
    result = calc;
    if (empty_plan) begin
      result          = '0;
      result.no_tiles = 1'b1;
    end
  end

  // Plan cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      at_start <= 1'b1;
    end else if (cfg_we) begin
      at_start <= 1'b1;
    end else if (accept) begin
      if (empty_plan) begin
        at_start <= 1'b1;
      end else begin
        cursor_x <= x_sel;
        cursor_y <= y_sel;
        at_start <= 1'b0;
      end
    end
  end

  // Output register and skid entry; input ready follows the skid, not output ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          out_data <= result;
        end
      end
    end else if (accept) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data.fields);
  assign m_axis_tuser  = out_data.no_tiles;
  assign m_axis_tlast  = out_data.last_tile;

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst, !skid_valid || out_valid,
                 "skid entry holds an item while the output register is empty")
  `ASSERT_ALWAYS(a_cursor_in_image, clk, rst,
                 at_start || ((cursor_x < image_width) && (cursor_y < image_height)),
                 "plan cursor lies outside the image")
  `ASSERT_ALWAYS(a_empty_result_clear, clk, rst,
                 !(out_valid && out_data.no_tiles) ||
                 ((out_data.fields == '0) && !out_data.last_tile),
                 "empty-plan result carries nonzero tile fields")
  `ASSERT_NEXT(a_plan_advances, clk, rst, accept && !empty_plan && !cfg_we, !at_start,
               "plan did not leave its start after a tile was issued")

endmodule
